// ===== hw/rtl/fsq_pkg.sv =====
`default_nettype none

package fsq_pkg;

   localparam int QUEUE_DEPTH     = 16;
   localparam int ALPHA_FRAC_BITS = 16;

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ALPHA_W = ALPHA_FRAC_BITS + 1;
   localparam int STEP_W  = $clog2(ALPHA_FRAC_BITS);
   localparam int DUR_W   = 32;
   localparam int TICK_W  = 16;
   localparam int PROD_W  = ALPHA_W + DUR_W;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic [1:0] MODE_FADE_OUT = 2'd0;
   localparam logic [1:0] MODE_STAY     = 2'd1;
   localparam logic [1:0] MODE_FADE_IN  = 2'd2;

   typedef struct packed {
      logic              operation;
      logic [1:0]        mode;
      logic [DUR_W-1:0]  duration;
      logic              skippable;
      logic [TICK_W-1:0] elapsed_ticks;
      logic              key_pressed;
   } req_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic               fading;
      logic               command_finished;
      logic               enqueue_dropped;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [DUR_W-1:0] duration;
      logic             skippable;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_DIV,
      ST_EVAL,
      ST_WALK_READ,
      ST_WALK_CHECK,
      ST_SCALE,
      ST_POP,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic capture;
      logic enq_write;
      logic set_drop;
      logic load_head;
      logic div_step;
      logic eval;
      logic walk_read;
      logic walk_next;
      logic walk_hit;
      logic walk_all;
      logic scale;
      logic pop;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic is_enq;
      logic full;
      logic empty;
      logic div_last;
      logic need_walk;
      logic done;
      logic walk_end;
      logic walk_found;
   } sts_type;

   // circular add, offset never exceeds the depth
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH))
         sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      return sum[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fsq_ram.sv =====
`default_nettype none

module fsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fsq_ctrl.sv =====
`default_nettype none

module fsq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire fsq_pkg::sts_type sts,
   output      fsq_pkg::cmd_type cmd
);
   import fsq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (!sts.is_enq && !sts.empty) state_in = ST_LOAD;
            else                          state_in = ST_RESPOND;
         end
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (sts.div_last) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (sts.need_walk)  state_in = ST_WALK_READ;
            else if (sts.done)  state_in = ST_POP;
            else                state_in = ST_RESPOND;
         end
         ST_WALK_READ: begin
            if (sts.walk_end) state_in = ST_POP;
            else              state_in = ST_WALK_CHECK;
         end
         ST_WALK_CHECK: begin
            if (sts.walk_found) state_in = ST_SCALE;
            else                state_in = ST_WALK_READ;
         end
         ST_SCALE: state_in = ST_POP;
         ST_POP:   state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.capture = req_valid;
         ST_DECODE: begin
            if (sts.is_enq) begin
               cmd.set_drop  = sts.full;
               cmd.enq_write = !sts.full;
            end
         end
         ST_LOAD: cmd.load_head = 1'b1;
         ST_DIV:  cmd.div_step  = 1'b1;
         ST_EVAL: cmd.eval      = 1'b1;
         ST_WALK_READ: begin
            cmd.walk_all  = sts.walk_end;
            cmd.walk_read = !sts.walk_end;
         end
         ST_WALK_CHECK: begin
            cmd.walk_hit  = sts.walk_found;
            cmd.walk_next = !sts.walk_found;
         end
         ST_SCALE:   cmd.scale   = 1'b1;
         ST_POP:     cmd.pop     = 1'b1;
         ST_RESPOND: cmd.respond = out_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.respond || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fsq_datapath.sv =====
`default_nettype none

module fsq_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fsq_pkg::req_type req_data,
   input  wire fsq_pkg::cmd_type cmd,
   output      fsq_pkg::sts_type sts,
   output      fsq_pkg::rsp_type rsp_data
);
   import fsq_pkg::*;

   // queue bookkeeping and alpha level
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;

   // working registers of one item
   req_type               req_ff, req_in;
   logic [DUR_W-1:0]      el_ff, el_in;
   logic [1:0]            mode_ff, mode_in;
   logic [DUR_W-1:0]      dur_ff, dur_in;
   logic                  skip_ff, skip_in;
   logic [DUR_W-1:0]      rem_ff, rem_in;
   logic [ALPHA_FRAC_BITS-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [ALPHA_W-1:0]    frac_ff, frac_in;
   logic [CNT_W-1:0]      walk_k_ff, walk_k_in;
   logic [CNT_W-1:0]      pop_ff, pop_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  fading_ff, fading_in;
   logic                  fin_ff, fin_in;
   logic                  drop_ff, drop_in;
   rsp_type               rsp_ff, rsp_in;

   // memories
   entry_type          ent_wr_data, ent_rd;
   logic [ENTRY_W-1:0] ent_rd_bits;
   logic               el_wr_en;
   logic [IDX_W-1:0]   el_wr_addr;
   logic [DUR_W-1:0]   el_wr_data, el_rd;
   logic [IDX_W-1:0]   rd_addr, tail, walk_slot;

   logic [DUR_W:0]       el_sum;
   logic [DUR_W-1:0]     el_sat;
   logic [DUR_W:0]       rem_sh, rem_diff;
   logic                 rem_ge;
   logic [ALPHA_W-1:0]   frac, alpha_new;
   logic                 skip_key, done, need_walk;
   logic [CNT_W-1:0]     count_left;

   assign tail      = wrap_add(head_ff, count_ff);
   assign walk_slot = wrap_add(head_ff, walk_k_ff);
   assign rd_addr   = cmd.walk_read ? walk_slot : head_ff;

   assign ent_wr_data.mode      = req_ff.mode;
   assign ent_wr_data.duration  = req_ff.duration;
   assign ent_wr_data.skippable = req_ff.skippable;

   fsq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.enq_write),
      .wr_addr (tail),
      .wr_data (ent_wr_data),
      .rd_addr (rd_addr),
      .rd_data (ent_rd_bits)
   );

   assign ent_rd = entry_type'(ent_rd_bits);

   fsq_ram #(.WIDTH(DUR_W), .DEPTH(QUEUE_DEPTH)) u_elapsed_ram (
      .clock   (clock),
      .wr_en   (el_wr_en),
      .wr_addr (el_wr_addr),
      .wr_data (el_wr_data),
      .rd_addr (rd_addr),
      .rd_data (el_rd)
   );

   always_comb begin
      el_wr_en   = cmd.enq_write || cmd.eval || cmd.scale;
      el_wr_addr = head_ff;
      el_wr_data = el_ff;
      if (cmd.enq_write) begin
         el_wr_addr = tail;
         el_wr_data = '0;
      end else if (cmd.scale) begin
         el_wr_addr = walk_slot;
         el_wr_data = prod_ff[ALPHA_FRAC_BITS +: DUR_W];
      end
   end

   // saturating elapsed update
   assign el_sum = (DUR_W + 1)'(el_rd) + (DUR_W + 1)'(req_ff.elapsed_ticks);
   assign el_sat = el_sum[DUR_W] ? '1 : el_sum[DUR_W-1:0];

   // one restoring division step, only used when elapsed < duration
   assign rem_sh   = {rem_ff, 1'b0};
   assign rem_ge   = rem_sh >= {1'b0, dur_ff};
   assign rem_diff = rem_sh - {1'b0, dur_ff};

   // elapsed >= duration (zero duration included) clamps to one
   assign frac     = (el_ff >= dur_ff) ? ALPHA_ONE : {1'b0, quo_ff};
   assign skip_key = skip_ff && req_ff.key_pressed;

   always_comb begin
      alpha_new = alpha_ff;
      done      = 1'b0;
      need_walk = 1'b0;
      unique case (mode_ff)
         MODE_FADE_OUT: begin
            alpha_new = frac;
            done      = (frac == ALPHA_ONE);
         end
         MODE_STAY: begin
            done = skip_key || (el_ff > dur_ff) || (dur_ff == '0);
         end
         MODE_FADE_IN: begin
            alpha_new = ALPHA_ONE - frac;
            need_walk = skip_key;
            done      = skip_key || (frac == ALPHA_ONE);
         end
         default: done = 1'b1;
      endcase
   end

   assign count_left = count_ff - pop_ff;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      alpha_in  = alpha_ff;
      req_in    = req_ff;
      el_in     = el_ff;
      mode_in   = mode_ff;
      dur_in    = dur_ff;
      skip_in   = skip_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      frac_in   = frac_ff;
      walk_k_in = walk_k_ff;
      pop_in    = pop_ff;
      prod_in   = prod_ff;
      fading_in = fading_ff;
      fin_in    = fin_ff;
      drop_in   = drop_ff;
      rsp_in    = rsp_ff;

      if (cmd.capture) begin
         req_in    = req_data;
         fading_in = 1'b0;
         fin_in    = 1'b0;
         drop_in   = 1'b0;
      end
      if (cmd.set_drop) drop_in = 1'b1;
      if (cmd.enq_write) count_in = count_ff + CNT_W'(1);
      if (cmd.load_head) begin
         el_in     = el_sat;
         mode_in   = ent_rd.mode;
         dur_in    = ent_rd.duration;
         skip_in   = ent_rd.skippable;
         rem_in    = el_sat;
         quo_in    = '0;
         step_in   = '0;
         fading_in = 1'b1;
      end
      if (cmd.div_step) begin
         if (rem_ge) rem_in = rem_diff[DUR_W-1:0];
         else        rem_in = rem_sh[DUR_W-1:0];
         quo_in  = {quo_ff[ALPHA_FRAC_BITS-2:0], rem_ge};
         step_in = step_ff + STEP_W'(1);
      end
      if (cmd.eval) begin
         alpha_in  = alpha_new;
         fin_in    = done;
         frac_in   = frac;
         walk_k_in = CNT_W'(1);
         pop_in    = CNT_W'(1);
      end
      if (cmd.walk_next) walk_k_in = walk_k_ff + CNT_W'(1);
      if (cmd.walk_hit) begin
         pop_in  = walk_k_ff;
         prod_in = PROD_W'(frac_ff) * PROD_W'(ent_rd.duration);
      end
      if (cmd.walk_all) pop_in = count_ff;
      if (cmd.pop) begin
         count_in = count_left;
         head_in  = (count_left == '0) ? '0 : wrap_add(head_ff, pop_ff);
      end
      if (cmd.respond) begin
         rsp_in.alpha            = alpha_ff;
         rsp_in.fading           = fading_ff;
         rsp_in.command_finished = fin_ff;
         rsp_in.enqueue_dropped  = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         alpha_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         alpha_ff <= alpha_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      el_ff     <= el_in;
      mode_ff   <= mode_in;
      dur_ff    <= dur_in;
      skip_ff   <= skip_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      frac_ff   <= frac_in;
      walk_k_ff <= walk_k_in;
      pop_ff    <= pop_in;
      prod_ff   <= prod_in;
      fading_ff <= fading_in;
      fin_ff    <= fin_in;
      drop_ff   <= drop_in;
      rsp_ff    <= rsp_in;
   end

   assign sts.is_enq     = (req_ff.operation == OP_ENQUEUE);
   assign sts.full       = (count_ff >= CNT_W'(QUEUE_DEPTH));
   assign sts.empty      = (count_ff == '0);
   assign sts.div_last   = (step_ff == STEP_W'(ALPHA_FRAC_BITS - 1));
   assign sts.need_walk  = need_walk;
   assign sts.done       = done;
   assign sts.walk_end   = (walk_k_ff >= count_ff);
   assign sts.walk_found = (ent_rd.mode == MODE_FADE_OUT);

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fade_sequencer_queue.sv =====
// fade_sequencer_queue: a queue of timed fade commands that drives an alpha level.
// Input channel req_valid / req_stall / req_data carries one item: an enqueue
// (mode, duration, skippable) or a tick (elapsed_ticks, key_pressed).
// Result channel rsp_valid / rsp_stall / rsp_data returns exactly one item per
// input item, in order: alpha (Q1.16), fading, command_finished, enqueue_dropped.
// One item is worked on at a time; req_stall is high from acceptance until the
// result has been loaded into the output register.
// An enqueue, or a tick on an empty queue, goes from decode straight to the
// response. A tick on a non-empty queue loads the head, runs the bit-serial
// fraction divider, evaluates and, when the head command completes, pops it. A
// skipped fade in first walks the queue, reading and checking one entry at a time.
// A new item is taken only once the last result is in the output register.
// The output register lets the next item be accepted while a result waits.
// While rsp_stall is high the result is held unchanged; a finished item then
// waits in its last step until the output register frees up.
// Reset (synchronous, active high) empties the queue, returns the head to slot 0
// and sets alpha to 0. Entry storage is not cleared and needs no clearing pass.
`default_nettype none

module fade_sequencer_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire fsq_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      fsq_pkg::rsp_type rsp_data
);
   import fsq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   fsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fsq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/fsq_checker.sv =====
`default_nettype none

module fsq_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire fsq_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire fsq_pkg::rsp_type rsp_data
);
   import fsq_pkg::*;

   // held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while one is in progress");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.alpha <= ALPHA_ONE)
      else $error("alpha above one");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.command_finished |-> rsp_data.fading)
      else $error("finished without an active command");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.enqueue_dropped |-> !rsp_data.fading)
      else $error("dropped enqueue reported as a tick");

endmodule

bind fade_sequencer_queue fsq_checker u_fsq_checker (.*);

`default_nettype wire

// ===== tb/fsq_alpha_checker.sv =====
module fsq_alpha_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  fsq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  fsq_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               outstanding,
   output int               queue_level
);
   timeunit 1ns;
   timeprecision 1ps;
   import fsq_pkg::*;

   // own copy of the fade command queue
   logic [1:0]         cmd_mode    [QUEUE_DEPTH];
   logic [DUR_W-1:0]   cmd_dur     [QUEUE_DEPTH];
   logic               cmd_skip    [QUEUE_DEPTH];
   logic [31:0]        cmd_elapsed [QUEUE_DEPTH];
   int unsigned        head;
   int unsigned        queued;
   logic [ALPHA_W-1:0] level;

   rsp_type alpha_due[$];
   rsp_type want;
   logic    bad;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      queue_level = 0;
      head        = 0;
      queued      = 0;
      level       = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cmd_mode[i]    = '0;
         cmd_dur[i]     = '0;
         cmd_skip[i]    = 1'b0;
         cmd_elapsed[i] = '0;
      end
   end

   function automatic logic [ALPHA_W-1:0] ramp_fraction(input logic [31:0] el,
                                                        input logic [31:0] dur);
      logic [63:0] quo;
      if (dur == '0)
         return ALPHA_ONE;
      quo = (64'(el) << ALPHA_FRAC_BITS) / 64'(dur);
      if (quo > 64'(ALPHA_ONE))
         return ALPHA_ONE;
      return quo[ALPHA_W-1:0];
   endfunction

   function automatic rsp_type apply_item(input req_type item);
      rsp_type            res;
      int unsigned        slot;
      int unsigned        pop;
      int unsigned        walk_slot;
      logic [32:0]        sum;
      logic [31:0]        el;
      logic [31:0]        dur;
      logic [ALPHA_W-1:0] frac;
      logic [63:0]        prod;
      logic               done;
      res = '0;
      if (item.operation == OP_ENQUEUE) begin
         if (queued >= QUEUE_DEPTH) begin
            res.enqueue_dropped = 1'b1;
         end else begin
            slot              = (head + queued) % QUEUE_DEPTH;
            cmd_mode[slot]    = item.mode;
            cmd_dur[slot]     = item.duration;
            cmd_skip[slot]    = item.skippable;
            cmd_elapsed[slot] = '0;
            queued++;
         end
      end else if (queued > 0) begin
         slot = head;
         dur  = cmd_dur[slot];
         sum  = {1'b0, cmd_elapsed[slot]} + 33'(item.elapsed_ticks);
         // elapsed time saturates instead of wrapping
         el   = sum[32] ? '1 : sum[31:0];
         cmd_elapsed[slot] = el;
         frac = ramp_fraction(el, dur);
         pop  = 1;
         done = 1'b0;
         res.fading = 1'b1;
         case (cmd_mode[slot])
            MODE_FADE_OUT: begin
               level = frac;
               done  = (frac == ALPHA_ONE);
            end
            MODE_STAY: begin
               done = (cmd_skip[slot] && item.key_pressed) || (el > dur) || (dur == '0);
            end
            MODE_FADE_IN: begin
               level = ALPHA_ONE - frac;
               if (cmd_skip[slot] && item.key_pressed) begin
                  done = 1'b1;
                  // drop everything up to the next fade out, which inherits the progress
                  pop  = queued;
                  for (int unsigned k = 1; k < queued; k++) begin
                     walk_slot = (head + k) % QUEUE_DEPTH;
                     if (cmd_mode[walk_slot] == MODE_FADE_OUT) begin
                        prod = 64'(frac) * 64'(cmd_dur[walk_slot]);
                        cmd_elapsed[walk_slot] = 32'(prod >> ALPHA_FRAC_BITS);
                        pop = k;
                        break;
                     end
                  end
               end
               if (level == '0)
                  done = 1'b1;
            end
            default: begin
               done = 1'b1;
            end
         endcase
         if (done) begin
            res.command_finished = 1'b1;
            if (pop > queued)
               pop = queued;
            queued = queued - pop;
            head   = (queued > 0) ? (head + pop) % QUEUE_DEPTH : 0;
         end
      end
      res.alpha = level;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         head   = 0;
         queued = 0;
         level  = '0;
         alpha_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (alpha_due.size() == 0) begin
               $display("%0t: result with nothing expected, actual %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = alpha_due.pop_front();
               bad  = 1'b0;
               if (rsp_data.alpha !== want.alpha) begin
                  $display("%0t: alpha expected %0d actual %0d",
                           $time, want.alpha, rsp_data.alpha);
                  bad = 1'b1;
               end
               if (rsp_data.fading !== want.fading) begin
                  $display("%0t: fading expected %0b actual %0b",
                           $time, want.fading, rsp_data.fading);
                  bad = 1'b1;
               end
               if (rsp_data.command_finished !== want.command_finished) begin
                  $display("%0t: command_finished expected %0b actual %0b",
                           $time, want.command_finished, rsp_data.command_finished);
                  bad = 1'b1;
               end
               if (rsp_data.enqueue_dropped !== want.enqueue_dropped) begin
                  $display("%0t: enqueue_dropped expected %0b actual %0b",
                           $time, want.enqueue_dropped, rsp_data.enqueue_dropped);
                  bad = 1'b1;
               end
               if (bad)
                  fail_count <= fail_count + 1;
            end
         end
         if (req_valid && !req_stall)
            alpha_due.push_back(apply_item(req_data));
      end
      outstanding <= alpha_due.size();
      queue_level <= queued;
   end

endmodule

// ===== tb/tb_fade_sequencer_queue.sv =====
module tb_fade_sequencer_queue;
   timeunit 1ns;
   timeprecision 1ps;
   import fsq_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1750;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int queue_level;
   int sent;
   int taken;

   fade_sequencer_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   fsq_alpha_checker alpha_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .queue_level (queue_level)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_fade_sequencer_queue: FAIL");
      $finish;
   end

   function automatic req_type make_cmd(input logic [1:0] mode, input logic [31:0] dur,
                                        input logic skip);
      req_type item;
      item.operation     = OP_ENQUEUE;
      item.mode          = mode;
      item.duration      = dur;
      item.skippable     = skip;
      item.elapsed_ticks = TICK_W'($urandom);
      item.key_pressed   = 1'($urandom);
      return item;
   endfunction

   function automatic req_type make_tick(input logic [15:0] ticks, input logic key);
      req_type item;
      item.operation     = OP_TICK;
      item.mode          = 2'($urandom);
      item.duration      = $urandom;
      item.skippable     = 1'($urandom);
      item.elapsed_ticks = ticks;
      item.key_pressed   = key;
      return item;
   endfunction

   function automatic req_type random_command();
      int          pick;
      logic [1:0]  mode;
      logic        skip;
      logic [31:0] dur;
      pick = $urandom_range(0, 19);
      if (pick < 7)
         mode = MODE_FADE_OUT;
      else if (pick < 12)
         mode = MODE_STAY;
      else if (pick < 19)
         mode = MODE_FADE_IN;
      else
         mode = MODE_UNUSED;
      skip = 1'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0)
         dur = '0;
      else if (pick < 7)
         dur = $urandom_range(1, 6000);
      else if (pick < 9)
         dur = $urandom_range(6001, 1 << 20);
      else if (skip && (mode == MODE_STAY || mode == MODE_FADE_IN))
         dur = $urandom;  // only a key press ends these
      else
         dur = $urandom_range(1, 200);
      return make_cmd(mode, dur, skip);
   endfunction

   function automatic req_type random_tick();
      int          pick;
      logic [15:0] ticks;
      pick = $urandom_range(0, 15);
      if (pick < 2)
         ticks = '0;
      else if (pick < 4)
         ticks = '1;
      else if (pick < 6)
         ticks = 16'($urandom);
      else
         ticks = $urandom_range(1, 3000);
      return make_tick(ticks, $urandom_range(0, 3) == 0);
   endfunction

   function automatic req_type random_noise();
      req_type item;
      item.operation     = 1'($urandom);
      item.mode          = 2'($urandom);
      // keep fade outs short enough that the queue keeps moving
      item.duration      = $urandom >> $urandom_range(12, 31);
      item.skippable     = 1'($urandom);
      item.elapsed_ticks = TICK_W'($urandom);
      item.key_pressed   = 1'($urandom);
      return item;
   endfunction

   task automatic send(input req_type item);
      int gap;
      gap = (((sent / 128) % 4) == 3) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // queue_level lags one item, so an extra tick on an empty queue may follow
   task automatic run_ticks(input int most);
      int n;
      n = 0;
      do begin
         send(random_tick());
         n++;
      end while (queue_level != 0 && n < most);
   endtask

   // result side
   initial begin
      int hold;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         hold = (((taken / 128) % 4) == 1) ? 0 : $urandom_range(0, 3);
         if (taken == HOLD_AT)
            hold = HOLD_CYCLES;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin
      int kind;
      int n;
      sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send(make_tick(16'hFFFF, 1'b1));
      send(make_cmd(MODE_FADE_OUT, 32'd0, 1'b0));
      send(make_tick(16'd0, 1'b0));
      // key press on a fade in that may not be skipped
      send(make_cmd(MODE_FADE_IN, 32'd1000, 1'b0));
      send(make_tick(16'd400, 1'b1));
      send(make_tick(16'hFFFF, 1'b0));
      send(make_cmd(MODE_STAY, 32'hFFFF_FFFF, 1'b1));
      send(make_tick(16'hFFFF, 1'b0));
      send(make_tick(16'd0, 1'b1));
      // stay ends only once elapsed passes the duration
      send(make_cmd(MODE_STAY, 32'd100, 1'b0));
      send(make_tick(16'd100, 1'b0));
      send(make_tick(16'd1, 1'b0));
      send(make_cmd(MODE_UNUSED, 32'd5, 1'b1));
      send(make_tick(16'd7, 1'b1));
      // skipped fade in hands its fraction to the fade out behind the stay
      send(make_cmd(MODE_FADE_IN, 32'd4000, 1'b1));
      send(make_cmd(MODE_STAY, 32'd10, 1'b0));
      send(make_cmd(MODE_FADE_OUT, 32'd524280, 1'b0));
      send(make_tick(16'd1000, 1'b1));
      repeat (6) send(make_tick(16'hFFFF, 1'b0));
      // skipped fade in with no fade out behind it empties the queue
      send(make_cmd(MODE_FADE_IN, 32'd50, 1'b1));
      send(make_cmd(MODE_STAY, 32'd0, 1'b1));
      send(make_cmd(MODE_FADE_IN, 32'd9, 1'b0));
      send(make_tick(16'd3, 1'b1));
      send(make_cmd(MODE_FADE_IN, 32'd0, 1'b1));
      send(make_tick(16'd0, 1'b0));

      n = sent + RANDOM_ITEMS;
      while (sent < n) begin
         kind = $urandom_range(0, 19);
         if (kind < 14) begin
            repeat ($urandom_range(1, 5)) send(random_command());
            run_ticks(60);
         end else if (kind < 16) begin
            // a burst of commands that can overfill the queue
            repeat ($urandom_range(14, 20)) send(random_command());
            run_ticks(80);
         end else if (kind < 18) begin
            repeat ($urandom_range(1, 8)) send(random_noise());
         end else if (kind == 18) begin
            wait_drained();
         end else begin
            repeat ($urandom_range(1, 10)) send(random_tick());
         end
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("tb_fade_sequencer_queue: PASS");
      else
         $display("tb_fade_sequencer_queue: FAIL");
      $finish;
   end

endmodule
